### rtl/swu_pkg.sv
// Shared types and constants for the stack with undo log.
// Used by swu_cell, swu_chain, swu_ctrl and stack_with_undo; depends on nothing.
package swu_pkg;

    localparam int DEPTH = 128;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [31:0]      word_t;
    typedef logic [1:0]       opcode_t;

    localparam opcode_t OP_PUSH = 2'd0;
    localparam opcode_t OP_POP  = 2'd1;
    localparam opcode_t OP_UNDO = 2'd2;

    localparam logic LOG_PUSH = 1'b0;
    localparam logic LOG_POP  = 1'b1;

    typedef enum logic [2:0] {
        ST_PUSHED    = 3'd0,
        ST_POPPED    = 3'd1,
        ST_UNDID_PUSH = 3'd2,
        ST_UNDID_POP = 3'd3,
        ST_EMPTY_POP = 3'd4,
        ST_NO_UNDO   = 3'd5,
        ST_FULL      = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_PUSH = 2'd1,
        SH_POP  = 2'd2
    } shift_t;

    // One entry of each of the three stacks, as held by one cell.
    typedef struct packed {
        word_t value;
        word_t removed;
        logic  hist;
    } cell_data_t;

    // Shift commands broadcast to every cell, one per stack.
    typedef struct packed {
        shift_t v_sh;
        shift_t r_sh;
        shift_t h_sh;
    } cell_ctrl_t;

endpackage

### rtl/swu_cell.sv
// One cell of the shifting stack: one entry of the value, removed and history stacks.
// Depends on swu_pkg.
module swu_cell (
    input  logic                aclk,
    input  swu_pkg::cell_ctrl_t ctrl,
    input  swu_pkg::cell_data_t push_in,
    input  swu_pkg::cell_data_t pop_in,
    output swu_pkg::cell_data_t q
);
    import swu_pkg::*;

    word_t value_reg, value_next;
    word_t removed_reg, removed_next;
    logic  hist_reg, hist_next;

    // On a push each entry moves one place deeper; on a pop one place up.
    always_comb begin
        case (ctrl.v_sh)
            SH_PUSH: value_next = push_in.value;
            SH_POP:  value_next = pop_in.value;
            default: value_next = value_reg;
        endcase
        case (ctrl.r_sh)
            SH_PUSH: removed_next = push_in.removed;
            SH_POP:  removed_next = pop_in.removed;
            default: removed_next = removed_reg;
        endcase
        case (ctrl.h_sh)
            SH_PUSH: hist_next = push_in.hist;
            SH_POP:  hist_next = pop_in.hist;
            default: hist_next = hist_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg   <= value_next;
        removed_reg <= removed_next;
        hist_reg    <= hist_next;
    end

    assign q.value   = value_reg;
    assign q.removed = removed_reg;
    assign q.hist    = hist_reg;

endmodule

### rtl/swu_chain.sv
// Row of DEPTH stack cells; cell 0 holds the top of every stack.
// Depends on swu_pkg and swu_cell.
module swu_chain (
    input  logic                aclk,
    input  swu_pkg::cell_ctrl_t ctrl,
    input  swu_pkg::cell_data_t ins,
    output swu_pkg::cell_data_t top
);
    import swu_pkg::*;

    cell_data_t cell_q [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        cell_data_t push_in;
        cell_data_t pop_in;

        if (i == 0) begin : g_first
            assign push_in = ins;
        end else begin : g_mid
            assign push_in = cell_q[i-1];
        end

        // The deepest cell has nothing below it and keeps its own contents.
        if (i == DEPTH - 1) begin : g_last
            assign pop_in = cell_q[i];
        end else begin : g_rest
            assign pop_in = cell_q[i+1];
        end

        swu_cell u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .push_in (push_in),
            .pop_in  (pop_in),
            .q       (cell_q[i])
        );
    end

    assign top = cell_q[0];

endmodule

### rtl/swu_ctrl.sv
// Operation decoder and fill counters of the three stacks.
// Depends on swu_pkg; drives the shift commands of swu_chain.
module swu_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  swu_pkg::opcode_t    opcode,
    input  swu_pkg::word_t      value,
    input  swu_pkg::cell_data_t top,
    output swu_pkg::cell_ctrl_t ctrl,
    output swu_pkg::cell_data_t ins,
    output swu_pkg::status_t    status,
    output swu_pkg::word_t      result_value,
    output logic [7:0]          stack_depth
);
    import swu_pkg::*;

    localparam cnt_t FULL_CNT = CNT_W'(DEPTH);
    localparam cnt_t ONE_CNT  = CNT_W'(1);

    cnt_t vc_reg, vc_next;
    cnt_t rc_reg, rc_next;
    cnt_t hc_reg, hc_next;

    cell_ctrl_t op_ctrl;
    cnt_t       vc_op, rc_op, hc_op;

    always_comb begin
        op_ctrl      = '{v_sh: SH_HOLD, r_sh: SH_HOLD, h_sh: SH_HOLD};
        ins          = '{value: value, removed: top.value, hist: LOG_PUSH};
        status       = ST_NO_UNDO;
        result_value = '0;
        vc_op        = vc_reg;
        rc_op        = rc_reg;
        hc_op        = hc_reg;
        case (opcode)
            OP_PUSH: begin
                if (vc_reg >= FULL_CNT || hc_reg >= FULL_CNT) begin
                    status = ST_FULL;
                end else begin
                    op_ctrl.v_sh = SH_PUSH;
                    op_ctrl.h_sh = SH_PUSH;
                    ins.hist     = LOG_PUSH;
                    vc_op        = vc_reg + ONE_CNT;
                    hc_op        = hc_reg + ONE_CNT;
                    status       = ST_PUSHED;
                    result_value = value;
                end
            end
            OP_POP: begin
                if (vc_reg == '0) begin
                    status = ST_EMPTY_POP;
                end else if (hc_reg >= FULL_CNT || rc_reg >= FULL_CNT) begin
                    status = ST_FULL;
                end else begin
                    op_ctrl.v_sh = SH_POP;
                    op_ctrl.r_sh = SH_PUSH;
                    op_ctrl.h_sh = SH_PUSH;
                    ins.removed  = top.value;
                    ins.hist     = LOG_POP;
                    vc_op        = vc_reg - ONE_CNT;
                    rc_op        = rc_reg + ONE_CNT;
                    hc_op        = hc_reg + ONE_CNT;
                    status       = ST_POPPED;
                    result_value = top.value;
                end
            end
            OP_UNDO: begin
                if (hc_reg == '0) begin
                    status = ST_NO_UNDO;
                end else if (top.hist == LOG_PUSH) begin
                    if (vc_reg != '0) begin
                        op_ctrl.v_sh = SH_POP;
                        op_ctrl.h_sh = SH_POP;
                        vc_op        = vc_reg - ONE_CNT;
                        hc_op        = hc_reg - ONE_CNT;
                        status       = ST_UNDID_PUSH;
                        result_value = top.value;
                    end
                end else if (rc_reg != '0 && vc_reg < FULL_CNT) begin
                    // Put the most recently removed value back on the main stack.
                    op_ctrl.v_sh = SH_PUSH;
                    op_ctrl.r_sh = SH_POP;
                    op_ctrl.h_sh = SH_POP;
                    ins.value    = top.removed;
                    vc_op        = vc_reg + ONE_CNT;
                    rc_op        = rc_reg - ONE_CNT;
                    hc_op        = hc_reg - ONE_CNT;
                    status       = ST_UNDID_POP;
                    result_value = top.removed;
                end
            end
            default: begin
                status = ST_NO_UNDO;
            end
        endcase
    end

    always_comb begin
        if (fire) begin
            ctrl    = op_ctrl;
            vc_next = vc_op;
            rc_next = rc_op;
            hc_next = hc_op;
        end else begin
            ctrl    = '{v_sh: SH_HOLD, r_sh: SH_HOLD, h_sh: SH_HOLD};
            vc_next = vc_reg;
            rc_next = rc_reg;
            hc_next = hc_reg;
        end
    end

    assign stack_depth = 8'(vc_op);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= '0;
            rc_reg <= '0;
            hc_reg <= '0;
        end else begin
            vc_reg <= vc_next;
            rc_reg <= rc_next;
            hc_reg <= hc_next;
        end
    end

endmodule

### rtl/stack_with_undo.sv
// Top level of the bounded stack with undo log.
// Depends on swu_pkg, swu_ctrl and swu_chain (which instantiates swu_cell).
//
// Usage
// The input channel (s_valid, s_ready, s_opcode, s_value) takes one operation
// per word: push s_value, pop, or undo the latest logged push or pop. Every
// operation gives exactly one result word on the output channel (m_valid,
// m_ready, m_status, m_result_value, m_stack_depth).
// The stacks are a row of cells that all shift together, with the top of
// every stack in the first cell, so an operation reads only the first cell
// and the fill counters. An operation is decided and applied in the cycle it
// is accepted; its result appears in the output register in the cycle after.
// One operation is taken every cycle while the receiver keeps m_ready high.
// While the receiver stalls, the result waits in the output register and
// s_ready falls, so at most one finished result is held; taking that result
// frees the register in the same cycle as the next operation is accepted.
// Reset (aresetn low at a clock edge) empties all three stacks by clearing
// their fill counters and drops any waiting result; the cell contents are
// left as they are, since no entry above a counter is ever read.
module stack_with_undo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_opcode,
    input  logic signed [31:0] s_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_status,
    output logic signed [31:0] m_result_value,
    output logic [7:0]        m_stack_depth
);
    import swu_pkg::*;

    logic       fire;
    cell_ctrl_t ctrl;
    cell_data_t ins;
    cell_data_t top;
    status_t    status;
    word_t      result_value;
    logic [7:0] stack_depth;

    logic       m_valid_reg, m_valid_next;
    logic [2:0] status_reg;
    word_t      result_reg;
    logic [7:0] depth_reg;

    // A new word may enter whenever the output register is empty or is
    // being emptied in this cycle.
    assign s_ready = !m_valid_reg || m_ready;
    assign fire    = s_valid && s_ready;

    swu_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .opcode       (s_opcode),
        .value        (s_value),
        .top          (top),
        .ctrl         (ctrl),
        .ins          (ins),
        .status       (status),
        .result_value (result_value),
        .stack_depth  (stack_depth)
    );

    swu_chain u_chain (
        .aclk (aclk),
        .ctrl (ctrl),
        .ins  (ins),
        .top  (top)
    );

    always_comb begin
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // The result payload needs no reset; it is loaded with each accepted word.
    always_ff @(posedge aclk) begin
        if (fire) begin
            status_reg <= status;
            result_reg <= result_value;
            depth_reg  <= stack_depth;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_result_value = result_reg;
    assign m_stack_depth  = depth_reg;

endmodule

### tb/undo_stack_check_pkg.sv
// Checker for the stack with undo log: holds its own copy of the three stacks
// and the queue of result words still owed by the block. Depends on swu_pkg.
package undo_stack_check_pkg;

    import swu_pkg::*;

    // Opcode 3 has no meaning; the block answers it as a no-op.
    localparam opcode_t OP_SPARE = 2'd3;

    typedef struct {
        status_t    status;
        word_t      value;
        logic [7:0] depth;
    } stack_word_t;

    class undo_stack_checker;

        word_t       held_vals[DEPTH];
        word_t       removed_vals[DEPTH];
        logic        op_log[DEPTH];
        int          n_held;
        int          n_removed;
        int          n_logged;
        stack_word_t pending_words[$];
        int          mismatch_count;

        function new();
            n_held = 0;
            n_removed = 0;
            n_logged = 0;
            mismatch_count = 0;
        endfunction

        // Applies one accepted operation to the local stacks and queues the
        // result word that the block owes for it.
        function void note_op(opcode_t op, word_t val);
            stack_word_t w;
            w.status = ST_NO_UNDO;
            w.value = '0;
            case (op)
                OP_PUSH: begin
                    if (n_held >= DEPTH || n_logged >= DEPTH) begin
                        w.status = ST_FULL;
                    end else begin
                        held_vals[n_held] = val;
                        n_held++;
                        op_log[n_logged] = LOG_PUSH;
                        n_logged++;
                        w.status = ST_PUSHED;
                        w.value = val;
                    end
                end
                OP_POP: begin
                    if (n_held == 0) begin
                        w.status = ST_EMPTY_POP;
                    end else if (n_logged >= DEPTH || n_removed >= DEPTH) begin
                        w.status = ST_FULL;
                    end else begin
                        n_held--;
                        w.value = held_vals[n_held];
                        removed_vals[n_removed] = w.value;
                        n_removed++;
                        op_log[n_logged] = LOG_POP;
                        n_logged++;
                        w.status = ST_POPPED;
                    end
                end
                OP_UNDO: begin
                    if (n_logged == 0) begin
                        w.status = ST_NO_UNDO;
                    end else if (op_log[n_logged-1] == LOG_PUSH) begin
                        if (n_held > 0) begin
                            n_held--;
                            w.value = held_vals[n_held];
                            n_logged--;
                            w.status = ST_UNDID_PUSH;
                        end
                    end else if (n_removed > 0 && n_held < DEPTH) begin
                        n_removed--;
                        w.value = removed_vals[n_removed];
                        held_vals[n_held] = w.value;
                        n_held++;
                        n_logged--;
                        w.status = ST_UNDID_POP;
                    end
                end
                default: begin
                    w.status = ST_NO_UNDO;
                end
            endcase
            w.depth = 8'(n_held);
            pending_words.push_back(w);
        endfunction

        // Compares one result word from the block with the oldest one owed.
        function void check_word(logic [2:0] status, word_t value, logic [7:0] depth);
            stack_word_t want;
            if (pending_words.size() == 0) begin
                $display("%0t: result word with none owed: status %0d value %0d depth %0d",
                         $time, status, $signed(value), depth);
                mismatch_count++;
                return;
            end
            want = pending_words.pop_front();
            if (status !== want.status) begin
                $display("%0t: status expected %0d, got %0d", $time, want.status, status);
                mismatch_count++;
            end
            if (value !== want.value) begin
                $display("%0t: result_value expected %0d, got %0d",
                         $time, $signed(want.value), $signed(value));
                mismatch_count++;
            end
            if (depth !== want.depth) begin
                $display("%0t: stack_depth expected %0d, got %0d", $time, want.depth, depth);
                mismatch_count++;
            end
        endfunction

    endclass

endpackage

### tb/tb_top.sv
// Top-level testbench for stack_with_undo: drives operation words, stalls the
// result side and checks every result word. Depends on swu_pkg and undo_stack_check_pkg.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import swu_pkg::*;
    import undo_stack_check_pkg::*;

    // Random operation words to send, not counting the spare opcode, which
    // the block merely answers as a no-op.
    localparam int N_RANDOM_OPS = 1700;
    // Set well above the longest sender gap plus the longest receiver stall for
    // every word, so this leaves ample headroom.
    localparam int CYCLE_LIMIT  = 500000;
    // Length of the single long stall of the receiver.
    localparam int HOLD_CYCLES  = 400;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_UNDO, MIX_EVEN} op_mix_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_opcode;
    logic signed [31:0] s_value;
    logic              m_valid;
    logic              m_ready;
    logic [2:0]        m_status;
    logic signed [31:0] m_result_value;
    logic [7:0]        m_stack_depth;

    undo_stack_checker stack_check = new();

    int cycle_count = 0;
    int words_seen  = 0;
    bit send_burst  = 1'b0;

    stack_with_undo u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_result_value (m_result_value),
        .m_stack_depth  (m_stack_depth)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Watchdog: a run that has not finished by now has hung somewhere.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[stack_with_undo] ERROR");
            $finish;
        end
    end

    // Every result word taken by the receiver is checked against the oldest
    // word owed. Outputs are sampled at the rising edge, whilst m_ready only
    // ever changes at the falling edge, so there is no race here.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            stack_check.check_word(m_status, m_result_value, m_stack_depth);
            words_seen++;
        end
    end

    // Gap after an accepted word: mostly none, often short, now and again long.
    // In burst segments the sender never pauses at all.
    function automatic int send_gap();
        int r;
        r = $urandom_range(0, 99);
        if (send_burst || r < 65) begin
            return 0;
        end
        if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Values lean towards the extremes of the signed range now and again.
    function automatic word_t pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Each mix but the even one favours one kind of operation, so that segments of it drive
    // the stacks to full, back to empty, or unwind the history entirely.
    function automatic opcode_t pick_op(op_mix_t mix);
        int r;
        int push_pct;
        int pop_pct;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                push_pct = 70;
                pop_pct  = 15;
            end
            MIX_DRAIN: begin
                push_pct = 15;
                pop_pct  = 70;
            end
            MIX_UNDO: begin
                push_pct = 15;
                pop_pct  = 15;
            end
            default: begin
                push_pct = 33;
                pop_pct  = 33;
            end
        endcase
        if (r < 2) begin
            return OP_SPARE;
        end
        if (r < 2 + push_pct) begin
            return OP_PUSH;
        end
        if (r < 2 + push_pct + pop_pct) begin
            return OP_POP;
        end
        return OP_UNDO;
    endfunction

    // Offers one operation word and waits for the handshake. The word is
    // noted with the checker at the edge that accepts it. s_valid is only
    // lowered if a gap follows, so back-to-back words keep it high.
    task automatic send_op(input opcode_t op, input word_t val);
        int gap;
        @(negedge aclk);
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_value  <= val;
        do @(posedge aclk); while (!s_ready);
        stack_check.note_op(op, val);
        gap = send_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // Receiver. It stalls at random, with calm stretches in which it never
    // stalls, and once holds off for a long stretch whilst the sender keeps
    // offering words, so that the output register fills and s_ready drops.
    initial begin : receiver
        int  stall_left;
        int  hold_left;
        int  phase_left;
        bit  calm;
        bit  held_once;
        stall_left = 0;
        hold_left  = 0;
        phase_left = 150;
        calm       = 1'b0;
        held_once  = 1'b0;
        m_ready    = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!held_once && words_seen >= 300) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (phase_left == 0) begin
                calm       = ~calm;
                phase_left = $urandom_range(100, 300);
            end else begin
                phase_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) begin
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                              : $urandom_range(1, 3);
                end
            end
        end
    end

    // Stimulus and the end of the run.
    initial begin : stimulus
        int      counted;
        int      seg_len;
        op_mix_t mix;
        opcode_t op;
        int      r;
        counted  = 0;
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_opcode = OP_PUSH;
        s_value  = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed opening: undo and pop on the empty stack, the spare
        // opcode, the extremes of the value, and undo of both a pop and a push.
        send_op(OP_UNDO, 32'h0000_0000);
        send_op(OP_POP, 32'h1234_5678);
        send_op(OP_SPARE, 32'hFFFF_FFFF);
        send_op(OP_PUSH, 32'h7FFF_FFFF);
        send_op(OP_PUSH, 32'h8000_0000);
        send_op(OP_PUSH, 32'h0000_0000);
        send_op(OP_PUSH, 32'hFFFF_FFFF);
        send_op(OP_POP, 32'h0000_0000);
        send_op(OP_POP, 32'hFFFF_FFFF);
        send_op(OP_UNDO, 32'h0000_0000);
        send_op(OP_UNDO, 32'h0000_0000);
        send_op(OP_UNDO, 32'h0000_0000);
        send_op(OP_PUSH, 32'hAAAA_AAAA);
        send_op(OP_PUSH, 32'h5555_5555);
        send_op(OP_SPARE, 32'h0000_0000);
        send_op(OP_POP, 32'h0000_0000);
        send_op(OP_POP, 32'h0000_0000);
        send_op(OP_POP, 32'h0000_0000);
        send_op(OP_POP, 32'h0000_0000);
        send_op(OP_POP, 32'h0000_0000);
        send_op(OP_UNDO, 32'h0000_0000);
        send_op(OP_UNDO, 32'h0000_0000);
        send_op(OP_UNDO, 32'h0000_0000);

        // Random segments, each with its own mix. Fill segments drive the
        // stack and the history to full; drain and undo segments bring them
        // back, so the full and empty cases recur throughout.
        while (counted < N_RANDOM_OPS) begin
            seg_len = $urandom_range(20, 150);
            r = $urandom_range(0, 99);
            if (r < 30) begin
                mix = MIX_FILL;
            end else if (r < 55) begin
                mix = MIX_DRAIN;
            end else if (r < 80) begin
                mix = MIX_UNDO;
            end else begin
                mix = MIX_EVEN;
            end
            send_burst = ($urandom_range(0, 3) == 0);
            repeat (seg_len) begin
                op = pick_op(mix);
                send_op(op, pick_value());
                if (op != OP_SPARE) begin
                    counted++;
                end
            end
        end
        send_burst = 1'b0;
        @(negedge aclk);
        s_valid <= 1'b0;

        // Wait for every owed word, and run on past that so that any
        // stray extra word from the block would be caught.
        while (stack_check.pending_words.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (stack_check.mismatch_count == 0 && stack_check.pending_words.size() == 0) begin
            $display("[stack_with_undo] OK");
        end else begin
            $display("[stack_with_undo] ERROR");
        end
        $finish;
    end

endmodule
